/* rtl/stmm_pkg.sv */
`default_nettype none
package stmm_pkg;

    localparam int FUNC_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 11;
    localparam int IN_IDX_W    = 10;
    localparam int IN_VAL_W    = 16;
    localparam int OUT_VAL_W   = 32;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 56;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_START  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISMATCH = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD_A,
        OP_LOAD_B,
        OP_INIT_SORT,
        OP_RD_KEY,
        OP_LATCH_KEY,
        OP_RD_SCAN,
        OP_CMP_SCAN,
        OP_WR_SORT,
        OP_INIT_MUL,
        OP_RD_A,
        OP_LATCH_A,
        OP_RD_S,
        OP_LATCH_S,
        OP_NEXT_A,
        OP_RD_P,
        OP_CMP_P,
        OP_APPEND,
        OP_INIT_OUT,
        OP_RD_OUT,
        OP_OUT_ENTRY,
        OP_OUT_EMPTY,
        OP_OUT_MISMATCH,
        OP_CLEAR
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_MISMATCH,
        S_SORT_J,
        S_SORT_KEY,
        S_SORT_RD,
        S_SORT_CMP,
        S_MUL_A,
        S_MUL_LATCH_A,
        S_MUL_S,
        S_MUL_LATCH_S,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_APPEND,
        S_OUT_START,
        S_OUT_EMPTY,
        S_OUT_RD,
        S_OUT_LD,
        S_CLEAR
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic dims_ok;
        logic j_done;
        logic kb_done;
        logic a_done;
        logic kp_done;
        logic col_match;
        logic p_match;
        logic p_empty;
        logic out_free;
        logic out_last;
    } dp_stat_t;

endpackage
`default_nettype wire

/* rtl/sparse_triplet_matrix_multiply.sv */
// Sparse matrix multiply on (row, column, value) triplets. Load transactions for A
// and B are taken one per cycle while idle; a start transaction checks that A's
// column count equals B's row count, orders B by column then row (stable),
// multiplies every A entry with each matching B entry, and accumulates into a
// result list kept in first-seen order. The results then leave on the master side
// with tlast on the final one, and all stores are emptied for the next run. Each
// step is one read of a single-port entry memory followed by one compare or
// update. Load or result entries beyond MAX_ENTRIES are dropped and every
// product result of that run reports overflow.
`default_nettype none
module sparse_triplet_matrix_multiply #(
    parameter int MAX_ENTRIES = 64,
    parameter int INDEX_BITS  = 10,
    parameter int VALUE_BITS  = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // row_index[9:0], col_index[19:10], entry_value[35:20], zero pad
    input  wire logic [stmm_pkg::IN_DATA_W-1:0]      s_tdata,
    // func[1:0]
    input  wire logic [stmm_pkg::FUNC_W-1:0]         s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // out_row[9:0], out_col[19:10], out_value[51:20], zero pad
    output logic [stmm_pkg::OUT_DATA_W-1:0]          m_tdata,
    // status[1:0]
    output logic [stmm_pkg::STATUS_W-1:0]            m_tuser,
    output logic                                     m_tlast,
    input  wire logic                                cfg_we,
    input  wire logic [stmm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [stmm_pkg::CFG_W-1:0]          cfg_data
);

    stmm_pkg::cmd_t     cmd;
    stmm_pkg::dp_stat_t stat;

    stmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .func     (s_tuser),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    stmm_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .INDEX_BITS  (INDEX_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

/* rtl/stmm_ctrl.sv */
`default_nettype none
module stmm_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic [stmm_pkg::FUNC_W-1:0]   func,
    input  wire stmm_pkg::dp_stat_t            stat,
    output logic                               s_tready,
    output stmm_pkg::cmd_t                     cmd
);

    stmm_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stmm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = stmm_pkg::OP_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            stmm_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    case (func)
                        stmm_pkg::FUNC_LOAD_A: cmd.op = stmm_pkg::OP_LOAD_A;
                        stmm_pkg::FUNC_LOAD_B: cmd.op = stmm_pkg::OP_LOAD_B;
                        stmm_pkg::FUNC_START:  state_next = stmm_pkg::S_CHECK;
                        default:               cmd.op = stmm_pkg::OP_NONE;
                    endcase
                end
            end
            stmm_pkg::S_CHECK:
            begin
                if (stat.dims_ok)
                begin
                    cmd.op     = stmm_pkg::OP_INIT_SORT;
                    state_next = stmm_pkg::S_SORT_J;
                end
                else
                begin
                    state_next = stmm_pkg::S_MISMATCH;
                end
            end
            stmm_pkg::S_MISMATCH:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = stmm_pkg::OP_OUT_MISMATCH;
                    state_next = stmm_pkg::S_CLEAR;
                end
            end
            stmm_pkg::S_SORT_J:
            begin
                if (stat.j_done)
                begin
                    cmd.op     = stmm_pkg::OP_INIT_MUL;
                    state_next = stmm_pkg::S_MUL_A;
                end
                else
                begin
                    cmd.op     = stmm_pkg::OP_RD_KEY;
                    state_next = stmm_pkg::S_SORT_KEY;
                end
            end
            stmm_pkg::S_SORT_KEY:
            begin
                cmd.op     = stmm_pkg::OP_LATCH_KEY;
                state_next = stmm_pkg::S_SORT_RD;
            end
            stmm_pkg::S_SORT_RD:
            begin
                if (stat.kb_done)
                begin
                    cmd.op     = stmm_pkg::OP_WR_SORT;
                    state_next = stmm_pkg::S_SORT_J;
                end
                else
                begin
                    cmd.op     = stmm_pkg::OP_RD_SCAN;
                    state_next = stmm_pkg::S_SORT_CMP;
                end
            end
            stmm_pkg::S_SORT_CMP:
            begin
                cmd.op     = stmm_pkg::OP_CMP_SCAN;
                state_next = stmm_pkg::S_SORT_RD;
            end
            stmm_pkg::S_MUL_A:
            begin
                if (stat.a_done)
                begin
                    state_next = stmm_pkg::S_OUT_START;
                end
                else
                begin
                    cmd.op     = stmm_pkg::OP_RD_A;
                    state_next = stmm_pkg::S_MUL_LATCH_A;
                end
            end
            stmm_pkg::S_MUL_LATCH_A:
            begin
                cmd.op     = stmm_pkg::OP_LATCH_A;
                state_next = stmm_pkg::S_MUL_S;
            end
            stmm_pkg::S_MUL_S:
            begin
                if (stat.j_done)
                begin
                    cmd.op     = stmm_pkg::OP_NEXT_A;
                    state_next = stmm_pkg::S_MUL_A;
                end
                else
                begin
                    cmd.op     = stmm_pkg::OP_RD_S;
                    state_next = stmm_pkg::S_MUL_LATCH_S;
                end
            end
            stmm_pkg::S_MUL_LATCH_S:
            begin
                cmd.op     = stmm_pkg::OP_LATCH_S;
                state_next = stat.col_match ? stmm_pkg::S_SRCH_RD : stmm_pkg::S_MUL_S;
            end
            stmm_pkg::S_SRCH_RD:
            begin
                if (stat.kp_done)
                begin
                    state_next = stmm_pkg::S_APPEND;
                end
                else
                begin
                    cmd.op     = stmm_pkg::OP_RD_P;
                    state_next = stmm_pkg::S_SRCH_CMP;
                end
            end
            stmm_pkg::S_SRCH_CMP:
            begin
                cmd.op     = stmm_pkg::OP_CMP_P;
                state_next = stat.p_match ? stmm_pkg::S_MUL_S : stmm_pkg::S_SRCH_RD;
            end
            stmm_pkg::S_APPEND:
            begin
                cmd.op     = stmm_pkg::OP_APPEND;
                state_next = stmm_pkg::S_MUL_S;
            end
            stmm_pkg::S_OUT_START:
            begin
                if (stat.p_empty)
                begin
                    state_next = stmm_pkg::S_OUT_EMPTY;
                end
                else
                begin
                    cmd.op     = stmm_pkg::OP_INIT_OUT;
                    state_next = stmm_pkg::S_OUT_RD;
                end
            end
            stmm_pkg::S_OUT_EMPTY:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = stmm_pkg::OP_OUT_EMPTY;
                    state_next = stmm_pkg::S_CLEAR;
                end
            end
            stmm_pkg::S_OUT_RD:
            begin
                cmd.op     = stmm_pkg::OP_RD_OUT;
                state_next = stmm_pkg::S_OUT_LD;
            end
            stmm_pkg::S_OUT_LD:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = stmm_pkg::OP_OUT_ENTRY;
                    state_next = stat.out_last ? stmm_pkg::S_CLEAR : stmm_pkg::S_OUT_RD;
                end
            end
            stmm_pkg::S_CLEAR:
            begin
                cmd.op     = stmm_pkg::OP_CLEAR;
                state_next = stmm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = stmm_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/stmm_datapath.sv */
`default_nettype none
module stmm_datapath #(
    parameter int MAX_ENTRIES = 64,
    parameter int INDEX_BITS  = 10,
    parameter int VALUE_BITS  = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire stmm_pkg::cmd_t                      cmd,
    output stmm_pkg::dp_stat_t                       stat,
    input  wire logic [stmm_pkg::IN_DATA_W-1:0]      s_tdata,
    input  wire logic                                cfg_we,
    input  wire logic [stmm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [stmm_pkg::CFG_W-1:0]          cfg_data,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [stmm_pkg::OUT_DATA_W-1:0]          m_tdata,
    output logic [stmm_pkg::STATUS_W-1:0]            m_tuser,
    output logic                                     m_tlast
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int EW = 2 * INDEX_BITS + VALUE_BITS;
    localparam int VW = stmm_pkg::OUT_VAL_W;
    localparam int PW = 2 * INDEX_BITS + VW;
    localparam int IW = stmm_pkg::IN_IDX_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    logic [EW-1:0] a_mem [MAX_ENTRIES];
    logic [EW-1:0] b_mem [MAX_ENTRIES];
    logic [EW-1:0] s_mem [MAX_ENTRIES];
    logic [PW-1:0] p_mem [MAX_ENTRIES];

    logic [EW-1:0] a_q_reg, b_q_reg, s_q_reg;
    logic [PW-1:0] p_q_reg;

    logic [CW-1:0] a_cnt_reg, a_cnt_next, b_cnt_reg, b_cnt_next, p_cnt_reg, p_cnt_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next, rank_reg, rank_next;
    logic [EW-1:0] key_reg, key_next, a_reg, a_next;
    logic [INDEX_BITS-1:0] s_col_reg, s_col_next;
    logic [VW-1:0] prod_reg, prod_next;
    logic [stmm_pkg::CFG_W-1:0] cols_a_reg, rows_b_reg;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [IW-1:0]                 out_row_reg, out_row_next, out_col_reg, out_col_next;
    logic [VW-1:0]                 out_val_reg, out_val_next;
    logic [stmm_pkg::STATUS_W-1:0] out_stat_reg, out_stat_next;
    logic                          out_last_reg, out_last_next;

    logic [INDEX_BITS-1:0] in_row, in_col;
    logic [VW-1:0]         in_val32;
    logic [EW-1:0]         in_entry;
    logic                  a_full, b_full, p_full;
    logic                  scan_before;
    logic signed [VALUE_BITS-1:0] av, sv;
    logic [VW-1:0]         av32, sv32;
    logic                  p_we;
    logic [AW-1:0]         p_waddr;
    logic [PW-1:0]         p_wdata;

    assign in_row   = INDEX_BITS'(s_tdata[IW-1:0]);
    assign in_col   = INDEX_BITS'(s_tdata[2*IW-1:IW]);
    assign in_val32 = VW'($signed(s_tdata[2*IW+stmm_pkg::IN_VAL_W-1:2*IW]));
    assign in_entry = {in_row, in_col, in_val32[VALUE_BITS-1:0]};

    assign a_full = (a_cnt_reg == MAX_CNT);
    assign b_full = (b_cnt_reg == MAX_CNT);
    assign p_full = (p_cnt_reg == MAX_CNT);

    // Stable order: by column, then row, then load position.
    always_comb
    begin
        logic [INDEX_BITS-1:0] kr, kc, jr, jc;
        kr = b_q_reg[EW-1 -: INDEX_BITS];
        kc = b_q_reg[EW-INDEX_BITS-1 -: INDEX_BITS];
        jr = key_reg[EW-1 -: INDEX_BITS];
        jc = key_reg[EW-INDEX_BITS-1 -: INDEX_BITS];
        scan_before = (kc < jc) || ((kc == jc) && (kr < jr)) ||
                      ((kc == jc) && (kr == jr) && (k_reg < j_reg));
    end

    assign av   = a_reg[VALUE_BITS-1:0];
    assign sv   = s_q_reg[VALUE_BITS-1:0];
    assign av32 = VW'(av);
    assign sv32 = VW'(sv);

    assign stat.dims_ok   = (cols_a_reg == rows_b_reg);
    assign stat.j_done    = (j_reg == b_cnt_reg);
    assign stat.kb_done   = (k_reg == b_cnt_reg);
    assign stat.a_done    = (i_reg == a_cnt_reg);
    assign stat.kp_done   = (k_reg == p_cnt_reg);
    assign stat.col_match = (a_reg[EW-INDEX_BITS-1 -: INDEX_BITS] ==
                             s_q_reg[EW-1 -: INDEX_BITS]);
    assign stat.p_match   = (p_q_reg[PW-1 -: 2*INDEX_BITS] ==
                             {a_reg[EW-1 -: INDEX_BITS], s_col_reg});
    assign stat.p_empty   = (p_cnt_reg == '0);
    assign stat.out_free  = !m_tvalid_reg || m_tready;
    assign stat.out_last  = (CW'(k_reg + 1'b1) == p_cnt_reg);

    always_comb
    begin
        p_we    = 1'b0;
        p_waddr = k_reg[AW-1:0];
        p_wdata = {p_q_reg[PW-1 -: 2*INDEX_BITS], p_q_reg[VW-1:0] + prod_reg};
        if (cmd.op == stmm_pkg::OP_CMP_P)
        begin
            p_we = stat.p_match;
        end
        else if (cmd.op == stmm_pkg::OP_APPEND)
        begin
            p_we    = !p_full;
            p_waddr = p_cnt_reg[AW-1:0];
            p_wdata = {a_reg[EW-1 -: INDEX_BITS], s_col_reg, prod_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == stmm_pkg::OP_LOAD_A && !a_full)
        begin
            a_mem[a_cnt_reg[AW-1:0]] <= in_entry;
        end
        if (cmd.op == stmm_pkg::OP_RD_A)
        begin
            a_q_reg <= a_mem[i_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == stmm_pkg::OP_LOAD_B && !b_full)
        begin
            b_mem[b_cnt_reg[AW-1:0]] <= in_entry;
        end
        if (cmd.op == stmm_pkg::OP_RD_KEY)
        begin
            b_q_reg <= b_mem[j_reg[AW-1:0]];
        end
        else if (cmd.op == stmm_pkg::OP_RD_SCAN)
        begin
            b_q_reg <= b_mem[k_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == stmm_pkg::OP_WR_SORT)
        begin
            s_mem[rank_reg[AW-1:0]] <= key_reg;
        end
        if (cmd.op == stmm_pkg::OP_RD_S)
        begin
            s_q_reg <= s_mem[j_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            p_mem[p_waddr] <= p_wdata;
        end
        if (cmd.op == stmm_pkg::OP_RD_P || cmd.op == stmm_pkg::OP_RD_OUT)
        begin
            p_q_reg <= p_mem[k_reg[AW-1:0]];
        end
    end

    always_comb
    begin
        a_cnt_next    = a_cnt_reg;
        b_cnt_next    = b_cnt_reg;
        p_cnt_next    = p_cnt_reg;
        ovf_next      = ovf_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        rank_next     = rank_reg;
        key_next      = key_reg;
        a_next        = a_reg;
        s_col_next    = s_col_reg;
        prod_next     = prod_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_val_next  = out_val_reg;
        out_stat_next = out_stat_reg;
        out_last_next = out_last_reg;
        case (cmd.op)
            stmm_pkg::OP_LOAD_A:
            begin
                if (a_full) ovf_next = 1'b1;
                else        a_cnt_next = a_cnt_reg + 1'b1;
            end
            stmm_pkg::OP_LOAD_B:
            begin
                if (b_full) ovf_next = 1'b1;
                else        b_cnt_next = b_cnt_reg + 1'b1;
            end
            stmm_pkg::OP_INIT_SORT: j_next = '0;
            stmm_pkg::OP_LATCH_KEY:
            begin
                key_next  = b_q_reg;
                rank_next = '0;
                k_next    = '0;
            end
            stmm_pkg::OP_CMP_SCAN:
            begin
                if (scan_before) rank_next = rank_reg + 1'b1;
                k_next = k_reg + 1'b1;
            end
            stmm_pkg::OP_WR_SORT:  j_next = j_reg + 1'b1;
            stmm_pkg::OP_INIT_MUL: i_next = '0;
            stmm_pkg::OP_LATCH_A:
            begin
                a_next = a_q_reg;
                j_next = '0;
            end
            stmm_pkg::OP_LATCH_S:
            begin
                j_next     = j_reg + 1'b1;
                k_next     = '0;
                s_col_next = s_q_reg[EW-INDEX_BITS-1 -: INDEX_BITS];
                prod_next  = av32 * sv32;
            end
            stmm_pkg::OP_NEXT_A: i_next = i_reg + 1'b1;
            stmm_pkg::OP_CMP_P:
            begin
                if (!stat.p_match) k_next = k_reg + 1'b1;
            end
            stmm_pkg::OP_APPEND:
            begin
                if (p_full) ovf_next = 1'b1;
                else        p_cnt_next = p_cnt_reg + 1'b1;
            end
            stmm_pkg::OP_INIT_OUT: k_next = '0;
            stmm_pkg::OP_OUT_ENTRY:
            begin
                m_tvalid_next = 1'b1;
                out_row_next  = IW'(p_q_reg[PW-1 -: INDEX_BITS]);
                out_col_next  = IW'(p_q_reg[PW-INDEX_BITS-1 -: INDEX_BITS]);
                out_val_next  = p_q_reg[VW-1:0];
                out_stat_next = ovf_reg ? stmm_pkg::STAT_OVERFLOW : stmm_pkg::STAT_OK;
                out_last_next = stat.out_last;
                k_next        = k_reg + 1'b1;
            end
            stmm_pkg::OP_OUT_EMPTY, stmm_pkg::OP_OUT_MISMATCH:
            begin
                m_tvalid_next = 1'b1;
                out_row_next  = '0;
                out_col_next  = '0;
                out_val_next  = '0;
                out_stat_next = (cmd.op == stmm_pkg::OP_OUT_EMPTY) ?
                                stmm_pkg::STAT_EMPTY : stmm_pkg::STAT_MISMATCH;
                out_last_next = 1'b1;
            end
            stmm_pkg::OP_CLEAR:
            begin
                a_cnt_next = '0;
                b_cnt_next = '0;
                p_cnt_next = '0;
                ovf_next   = 1'b0;
            end
            default:
            begin
                ovf_next = ovf_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_cnt_reg    <= '0;
            b_cnt_reg    <= '0;
            p_cnt_reg    <= '0;
            ovf_reg      <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            rank_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            cols_a_reg   <= stmm_pkg::CFG_W'(1);
            rows_b_reg   <= stmm_pkg::CFG_W'(1);
        end
        else
        begin
            a_cnt_reg    <= a_cnt_next;
            b_cnt_reg    <= b_cnt_next;
            p_cnt_reg    <= p_cnt_next;
            ovf_reg      <= ovf_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            rank_reg     <= rank_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we && cfg_index == stmm_pkg::CFG_COLS_A)
            begin
                cols_a_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == stmm_pkg::CFG_ROWS_B)
            begin
                rows_b_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        a_reg        <= a_next;
        s_col_reg    <= s_col_next;
        prod_reg     <= prod_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_val_reg  <= out_val_next;
        out_stat_reg <= out_stat_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(stmm_pkg::OUT_DATA_W - 2*IW - VW){1'b0}},
                       out_val_reg, out_col_reg, out_row_reg};
    assign m_tuser  = out_stat_reg;
    assign m_tlast  = out_last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        a_cnt_reg <= MAX_CNT && b_cnt_reg <= MAX_CNT && p_cnt_reg <= MAX_CNT)
        else $error("entry count beyond capacity");

    out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == stmm_pkg::OP_OUT_ENTRY || cmd.op == stmm_pkg::OP_OUT_EMPTY ||
         cmd.op == stmm_pkg::OP_OUT_MISMATCH) |-> stat.out_free)
        else $error("result loaded over a pending transaction");

    clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == stmm_pkg::OP_CLEAR |=>
        (a_cnt_reg == '0 && b_cnt_reg == '0 && p_cnt_reg == '0 && !ovf_reg))
        else $error("stores not cleared after a run");

    rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == stmm_pkg::OP_WR_SORT |-> rank_reg < b_cnt_reg)
        else $error("sort rank out of range");

endmodule
`default_nettype wire

/* sim/product_checker.sv */
`default_nettype none
module product_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [stmm_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire logic [stmm_pkg::FUNC_W-1:0]       s_tuser,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [stmm_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  wire logic [stmm_pkg::STATUS_W-1:0]     m_tuser,
    input  wire logic                              m_tlast,
    input  wire logic                              cfg_we,
    input  wire logic [stmm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [stmm_pkg::CFG_W-1:0]        cfg_data,
    output int                                     fail_count,
    output int                                     pending
);

    localparam int DEPTH = 64;

    typedef struct packed {
        logic [9:0]  row;
        logic [9:0]  col;
        logic [31:0] value;
        logic [1:0]  status;
        logic        last;
    } entry_t;

    logic [10:0] cols_a_reg, rows_b_reg;
    logic [9:0]  a_row [DEPTH], a_col [DEPTH], b_row [DEPTH], b_col [DEPTH];
    logic [31:0] a_val [DEPTH], b_val [DEPTH];
    int          a_num, b_num;
    bit          overflow;
    entry_t      expected_products [$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic compute_product();
        logic [9:0]  pr [DEPTH], pc [DEPTH], tr, tc;
        logic [31:0] pv [DEPTH], tv, prod;
        int          pn, j, k;
        bit          hit;
        entry_t      e;
        if (cols_a_reg != rows_b_reg)
        begin
            expected_products.push_back({10'd0, 10'd0, 32'd0, stmm_pkg::STAT_MISMATCH, 1'b1});
        end
        else
        begin
            for (int i = 1; i < b_num; i++)
            begin
                tr = b_row[i]; tc = b_col[i]; tv = b_val[i];
                j = i;
                while (j > 0 && (b_col[j-1] > tc || (b_col[j-1] == tc && b_row[j-1] > tr)))
                begin
                    b_row[j] = b_row[j-1]; b_col[j] = b_col[j-1]; b_val[j] = b_val[j-1];
                    j--;
                end
                b_row[j] = tr; b_col[j] = tc; b_val[j] = tv;
            end
            pn = 0;
            for (int i = 0; i < a_num; i++)
            begin
                for (int m = 0; m < b_num; m++)
                begin
                    if (a_col[i] == b_row[m])
                    begin
                        prod = a_val[i] * b_val[m];
                        hit = 0;
                        for (k = 0; k < pn; k++)
                        begin
                            if (!hit && pr[k] == a_row[i] && pc[k] == b_col[m])
                            begin
                                pv[k] += prod;
                                hit = 1;
                            end
                        end
                        if (!hit)
                        begin
                            if (pn < DEPTH)
                            begin
                                pr[pn] = a_row[i]; pc[pn] = b_col[m]; pv[pn] = prod;
                                pn++;
                            end
                            else overflow = 1;
                        end
                    end
                end
            end
            if (pn == 0)
            begin
                expected_products.push_back({10'd0, 10'd0, 32'd0, stmm_pkg::STAT_EMPTY, 1'b1});
            end
            else
            begin
                for (k = 0; k < pn; k++)
                begin
                    e.row = pr[k]; e.col = pc[k]; e.value = pv[k];
                    e.status = overflow ? stmm_pkg::STAT_OVERFLOW : stmm_pkg::STAT_OK;
                    e.last = (k == pn - 1);
                    expected_products.push_back(e);
                end
            end
        end
        a_num = 0; b_num = 0; overflow = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        entry_t want;
        if (!rst_n)
        begin
            cols_a_reg <= 11'd1;
            rows_b_reg <= 11'd1;
            a_num = 0; b_num = 0; overflow = 0;
            fail_count = 0;
            pending = expected_products.size();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_products.size() == 0)
                begin
                    report("unexpected result", m_tdata[31:0], 32'd0);
                end
                else
                begin
                    want = expected_products.pop_front();
                    if (m_tdata[9:0] != want.row)
                        report("out_row", 32'(m_tdata[9:0]), 32'(want.row));
                    if (m_tdata[19:10] != want.col)
                        report("out_col", 32'(m_tdata[19:10]), 32'(want.col));
                    if (m_tdata[51:20] != want.value)
                        report("out_value", m_tdata[51:20], want.value);
                    if (m_tuser != want.status)
                        report("status", 32'(m_tuser), 32'(want.status));
                    if (m_tlast != want.last)
                        report("last", 32'(m_tlast), 32'(want.last));
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == stmm_pkg::CFG_COLS_A) cols_a_reg <= cfg_data;
                if (cfg_index == stmm_pkg::CFG_ROWS_B) rows_b_reg <= cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == stmm_pkg::FUNC_LOAD_A || s_tuser == stmm_pkg::FUNC_LOAD_B)
                begin
                    if ((s_tuser == stmm_pkg::FUNC_LOAD_A ? a_num : b_num) >= DEPTH)
                        overflow = 1;
                    else if (s_tuser == stmm_pkg::FUNC_LOAD_A)
                    begin
                        a_row[a_num] = s_tdata[9:0]; a_col[a_num] = s_tdata[19:10];
                        a_val[a_num] = {{16{s_tdata[35]}}, s_tdata[35:20]};
                        a_num++;
                    end
                    else
                    begin
                        b_row[b_num] = s_tdata[9:0]; b_col[b_num] = s_tdata[19:10];
                        b_val[b_num] = {{16{s_tdata[35]}}, s_tdata[35:20]};
                        b_num++;
                    end
                end
                else if (s_tuser == stmm_pkg::FUNC_START)
                begin
                    compute_product();
                end
            end
            pending = expected_products.size();
        end
    end
endmodule
`default_nettype wire

/* sim/testbench.sv */
`default_nettype none
module testbench;

    logic                              clk, rst_n;
    logic                              s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
    logic [stmm_pkg::IN_DATA_W-1:0]    s_tdata;
    logic [stmm_pkg::FUNC_W-1:0]       s_tuser;
    logic [stmm_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic [stmm_pkg::STATUS_W-1:0]     m_tuser;
    logic                              cfg_we;
    logic [stmm_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [stmm_pkg::CFG_W-1:0]        cfg_data;
    int                                fail_count, pending;
    int                                hold_off;
    int                                burst_left;

    sparse_triplet_matrix_multiply i_dut (.*);

    product_checker i_checker (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send(input logic [1:0] func, input logic [9:0] row,
                        input logic [9:0] col, input logic [15:0] value);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(0, 4)) @(posedge clk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {4'd0, value, col, row};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (burst_left == 0) s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_reg(input logic [1:0] index, input logic [10:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_run(input int n_a, input int n_b, input int span);
        for (int i = 0; i < n_a + n_b; i++)
            send((i < n_a) ? stmm_pkg::FUNC_LOAD_A : stmm_pkg::FUNC_LOAD_B,
                 10'($urandom_range(0, span)), 10'($urandom_range(0, span)),
                 16'($urandom));
        send(stmm_pkg::FUNC_START, 10'($urandom), 10'($urandom), 16'($urandom));
    endtask

    initial
    begin
        rst_n = 0; s_tvalid = 0; s_tdata = '0; s_tuser = '0; m_tready = 0;
        cfg_we = 0; cfg_index = '0; cfg_data = '0; hold_off = 0; burst_left = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int k = 0; k < 4; k++) set_reg(2'(k), 11'd1024);
        send(stmm_pkg::FUNC_LOAD_A, 10'd0, 10'd1023, 16'h8000);
        send(stmm_pkg::FUNC_LOAD_A, 10'd1023, 10'd1023, 16'h7FFF);
        send(stmm_pkg::FUNC_LOAD_B, 10'd1023, 10'd1023, 16'h8000);
        send(stmm_pkg::FUNC_LOAD_B, 10'd1023, 10'd0, 16'hFFFF);
        send(stmm_pkg::FUNC_UNUSED, 10'd5, 10'd5, 16'd5);
        send(stmm_pkg::FUNC_START, 10'd0, 10'd0, 16'd0);
        send(stmm_pkg::FUNC_LOAD_A, 10'd1, 10'd2, 16'd3);
        send(stmm_pkg::FUNC_LOAD_B, 10'd3, 10'd4, 16'd5);
        send(stmm_pkg::FUNC_START, 10'd0, 10'd0, 16'd0);
        send(stmm_pkg::FUNC_START, 10'd0, 10'd0, 16'd0);
        drain();
        set_reg(stmm_pkg::CFG_ROWS_B, 11'd7);
        send(stmm_pkg::FUNC_LOAD_A, 10'd1, 10'd1, 16'd1);
        send(stmm_pkg::FUNC_START, 10'd0, 10'd0, 16'd0);
        drain();
        set_reg(stmm_pkg::CFG_ROWS_B, 11'd1024);
        set_reg(stmm_pkg::CFG_COLS_A, 11'd1024);
        // A full store drops the extra entries and marks every result.
        for (int i = 0; i < 66; i++) send(stmm_pkg::FUNC_LOAD_A, 10'(i), 10'd0, 16'(i + 1));
        send(stmm_pkg::FUNC_LOAD_B, 10'd0, 10'd9, 16'd2);
        hold_off = 6000;
        send(stmm_pkg::FUNC_START, 10'd0, 10'd0, 16'd0);
        random_run(3, 3, 3);
        drain();
        for (int run = 0; run < 12; run++)
        begin
            set_reg(2'($urandom_range(0, 3)), 11'($urandom_range(1, 1024)));
            if ($urandom_range(0, 3) != 0)
            begin
                set_reg(stmm_pkg::CFG_COLS_A, 11'd5);
                set_reg(stmm_pkg::CFG_ROWS_B, 11'd5);
            end
            else set_reg(stmm_pkg::CFG_COLS_A, 11'd1);
            random_run($urandom_range(0, 6), $urandom_range(0, 6),
                       ($urandom_range(0, 4) == 0) ? 1023 : 3);
            if ($urandom_range(0, 3) == 0)
                send(stmm_pkg::FUNC_UNUSED, 10'($urandom), 10'($urandom), 16'($urandom));
            drain();
        end
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
